// ----- src/card_module_lifecycle_alarms_defines.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef CARD_MODULE_LIFECYCLE_ALARMS_DEFINES_SVH
`define CARD_MODULE_LIFECYCLE_ALARMS_DEFINES_SVH

`ifndef SYNTHESIS
`define CMLA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cmla assertion failed");
`define CMLA_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("cmla reset assertion failed");
`else
`define CMLA_ASSERT(lbl, prop)
`define CMLA_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- src/cmla_pkg.sv -----
package cmla_pkg;

  localparam int unsigned PORT_W       = 8;
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned TYPE_W       = 8;
  localparam int unsigned DELAY_W      = 32;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned NUM_PORTS_DEF = 8;
  localparam logic [DELAY_W-1:0] INIT_DELAY_RST = 32'd1000;

  typedef enum logic [2:0] {
    LIFE_ABSENT      = 3'd0,
    LIFE_WAIT_PROV   = 3'd1,
    LIFE_WAIT_PARENT = 3'd2,
    LIFE_INIT        = 3'd3,
    LIFE_READY       = 3'd4,
    LIFE_MISMATCH    = 3'd5
  } life_e;

  typedef enum logic [2:0] {
    RSN_NONE         = 3'd0,
    RSN_NOT_EQUIPPED = 3'd1,
    RSN_MISMATCH     = 3'd2,
    RSN_NOT_PROV     = 3'd3,
    RSN_ADMIN_DOWN   = 3'd4,
    RSN_PARENT       = 3'd5,
    RSN_INIT         = 3'd6
  } rsn_e;

  typedef enum logic [1:0] {
    ALM_NONE     = 2'd0,
    ALM_MISSING  = 2'd1,
    ALM_MISMATCH = 2'd2
  } alm_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROV_CARD   = 3'd0,
    CFG_CARD_ADMIN  = 3'd1,
    CFG_PROV_MODULE = 3'd2,
    CFG_MOD_ADMIN   = 3'd3,
    CFG_PORT_ADMIN  = 3'd4,
    CFG_CARD_DELAY  = 3'd5,
    CFG_MOD_DELAY   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TIME_W-1:0] now_time;
    logic [TYPE_W-1:0] card_type;
    logic [TYPE_W-1:0] module_type;
    logic [PORT_W-1:0] carrier;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        card_life;
    logic [2:0]        card_reason;
    logic [2:0]        module_life;
    logic [2:0]        module_reason;
    logic              is_operational;
    logic              operational_changed;
    logic              deadline_valid;
    logic [TIME_W-1:0] first_deadline;
    logic [PORT_W-1:0] port_up_mask;
    logic [PORT_W-1:0] port_alarm_mask;
    logic [1:0]        card_alarm;
    logic [1:0]        module_alarm;
  } out_word_t;

  typedef struct packed {
    life_e life;
    rsn_e  reason;
    logic  compat;
    logic  pend;
  } life_stat_t;

  function automatic alm_e equip_alarm(logic [TYPE_W-1:0] prov, logic admin, life_e life);
    alm_e a;
    a = ALM_NONE;
    if (prov != '0 && admin) begin
      if (life == LIFE_MISMATCH) begin
        a = ALM_MISMATCH;
      end else if (life == LIFE_ABSENT) begin
        a = ALM_MISSING;
      end
    end
    return a;
  endfunction

endpackage

// ----- src/cmla_life.sv -----
module cmla_life import cmla_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [TIME_W-1:0]   now_i,
  input  logic [TYPE_W-1:0]   equip_i,
  input  logic [TYPE_W-1:0]   prov_i,
  input  logic                admin_i,
  input  logic                parent_ok_i,
  input  logic [DELAY_W-1:0]  delay_i,
  output life_stat_t          stat_o,
  output logic [TIME_W-1:0]   deadline_o,
  output logic                ready_o
);

  life_e             life_q;
  logic              compat_q;
  logic [TIME_W-1:0] dl_q, dl_d;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sat;
  logic [TIME_W-1:0] dl_adv;
  logic              fresh;
  logic              compat;

  assign compat = (equip_i == '0) || (prov_i == '0) || (equip_i == prov_i);
  assign sum    = {1'b0, now_i} + (TIME_W+1)'(delay_i);
  assign sat    = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign fresh  = (life_q != LIFE_INIT) && (life_q != LIFE_READY);
  assign dl_adv = fresh ? sat : dl_q;

  always_comb begin
    stat_o.compat = compat;
    stat_o.pend   = 1'b0;
    stat_o.life   = life_q;
    stat_o.reason = RSN_NONE;
    dl_d          = '0;
    if (equip_i == '0) begin
      stat_o.life   = LIFE_ABSENT;
      stat_o.reason = RSN_NOT_EQUIPPED;
    end else if (!compat) begin
      stat_o.life   = LIFE_MISMATCH;
      stat_o.reason = RSN_MISMATCH;
    end else if (prov_i == '0 || !admin_i) begin
      stat_o.life   = LIFE_WAIT_PROV;
      stat_o.reason = admin_i ? RSN_NOT_PROV : RSN_ADMIN_DOWN;
    end else if (!parent_ok_i) begin
      stat_o.life   = LIFE_WAIT_PARENT;
      stat_o.reason = RSN_PARENT;
    end else begin
      dl_d = dl_adv;
      if (life_q == LIFE_READY || now_i >= dl_adv) begin
        stat_o.life   = LIFE_READY;
        stat_o.reason = RSN_NONE;
      end else begin
        stat_o.life   = LIFE_INIT;
        stat_o.reason = RSN_INIT;
        stat_o.pend   = 1'b1;
      end
    end
  end

  assign deadline_o = dl_d;
  assign ready_o    = compat_q && (life_q == LIFE_READY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q   <= LIFE_ABSENT;
      compat_q <= 1'b0;
      dl_q     <= '0;
    end else if (step_i) begin
      life_q   <= stat_o.life;
      compat_q <= stat_o.compat;
      dl_q     <= dl_d;
    end
  end

endmodule

// ----- src/card_module_lifecycle_alarms.sv -----
// Card and child-module lifecycle tracker with equipment and port link alarms. Each input
// word is one reconcile event (time, equipped card and module types, port carrier bits) and
// yields exactly one result word. The event sits in an input register while
// the card and module lifecycles, the 48-bit deadline add and compare, and the per-port
// latches are evaluated, and the result is captured in an output register. One word per cycle
// is sustained, limited only by the output stall. Configuration writes take effect at once
// and are meant to happen while no event is in flight.
`include "card_module_lifecycle_alarms_defines.svh"

module card_module_lifecycle_alarms import cmla_pkg::*; #(
  parameter int unsigned NUM_PORTS = NUM_PORTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_word_t              in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_word_t             out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned NP = (NUM_PORTS < PORT_W) ? NUM_PORTS : PORT_W;

  logic [TYPE_W-1:0]  prov_card_q, prov_mod_q;
  logic               card_admin_q, mod_admin_q;
  logic [PORT_W-1:0]  port_admin_q;
  logic [DELAY_W-1:0] card_delay_q, mod_delay_q;

  logic      in_valid_q, out_valid_q, en, step, in_acc;
  in_word_t  in_q;
  out_word_t out_q, out_d;

  life_stat_t        card_st, mod_st;
  logic [TIME_W-1:0] card_dl, mod_dl;
  logic              card_rdy, mod_rdy;
  logic              was_op, now_op;

  logic [NP-1:0] seen_q, seen_d, latch_q, latch_d, up, alarm;
  logic [NP-1:0] adm, lnk;

  assign en         = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && en;
  assign in_stall_o = in_valid_q && !en;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prov_card_q  <= '0;
      card_admin_q <= 1'b0;
      prov_mod_q   <= '0;
      mod_admin_q  <= 1'b0;
      port_admin_q <= '0;
      card_delay_q <= INIT_DELAY_RST;
      mod_delay_q  <= INIT_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROV_CARD:   prov_card_q  <= cfg_wdata_i[TYPE_W-1:0];
        CFG_CARD_ADMIN:  card_admin_q <= cfg_wdata_i[0];
        CFG_PROV_MODULE: prov_mod_q   <= cfg_wdata_i[TYPE_W-1:0];
        CFG_MOD_ADMIN:   mod_admin_q  <= cfg_wdata_i[0];
        CFG_PORT_ADMIN:  port_admin_q <= cfg_wdata_i[PORT_W-1:0];
        CFG_CARD_DELAY:  card_delay_q <= cfg_wdata_i[DELAY_W-1:0];
        CFG_MOD_DELAY:   mod_delay_q  <= cfg_wdata_i[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  cmla_life u_card (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .now_i      (in_q.now_time),
    .equip_i    (in_q.card_type),
    .prov_i     (prov_card_q),
    .admin_i    (card_admin_q),
    .parent_ok_i(1'b1),
    .delay_i    (card_delay_q),
    .stat_o     (card_st),
    .deadline_o (card_dl),
    .ready_o    (card_rdy)
  );

  cmla_life u_module (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .now_i      (in_q.now_time),
    .equip_i    (in_q.module_type),
    .prov_i     (prov_mod_q),
    .admin_i    (mod_admin_q),
    .parent_ok_i(card_st.life == LIFE_READY),
    .delay_i    (mod_delay_q),
    .stat_o     (mod_st),
    .deadline_o (mod_dl),
    .ready_o    (mod_rdy)
  );

  assign was_op = (prov_card_q != '0) && (prov_mod_q != '0) && card_admin_q && mod_admin_q &&
                  card_rdy && mod_rdy;
  assign now_op = (prov_card_q != '0) && (prov_mod_q != '0) && card_admin_q && mod_admin_q &&
                  card_st.compat && mod_st.compat &&
                  (card_st.life == LIFE_READY) && (mod_st.life == LIFE_READY);

  assign adm = port_admin_q[NP-1:0];
  assign lnk = in_q.carrier[NP-1:0];

  always_comb begin
    seen_d  = seen_q;
    latch_d = latch_q;
    up      = '0;
    alarm   = '0;
    for (int i = 0; i < NP; i++) begin
      up[i] = now_op && adm[i] && lnk[i];
      if (!adm[i]) begin
        seen_d[i]  = 1'b0;
        latch_d[i] = 1'b0;
      end else if (up[i]) begin
        seen_d[i]  = 1'b1;
        latch_d[i] = 1'b0;
      end else if (now_op && seen_q[i]) begin
        latch_d[i] = 1'b1;
      end
      alarm[i] = now_op && latch_d[i];
    end
  end

  always_comb begin
    out_d.card_life           = card_st.life;
    out_d.card_reason         = card_st.reason;
    out_d.module_life         = mod_st.life;
    out_d.module_reason       = mod_st.reason;
    out_d.is_operational      = now_op;
    out_d.operational_changed = now_op != was_op;
    out_d.deadline_valid      = card_st.pend || mod_st.pend;
    if (card_st.pend && (!mod_st.pend || card_dl <= mod_dl)) begin
      out_d.first_deadline = card_dl;
    end else if (mod_st.pend) begin
      out_d.first_deadline = mod_dl;
    end else begin
      out_d.first_deadline = '0;
    end
    out_d.port_up_mask    = PORT_W'(up);
    out_d.port_alarm_mask = PORT_W'(alarm);
    out_d.card_alarm      = equip_alarm(prov_card_q, card_admin_q, card_st.life);
    out_d.module_alarm    = equip_alarm(prov_mod_q, mod_admin_q, mod_st.life);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
      latch_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (en) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        seen_q  <= seen_d;
        latch_q <= latch_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_word_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `CMLA_ASSERT(a_op_card, out_valid_q && out_q.is_operational |-> out_q.card_life == LIFE_READY)
  `CMLA_ASSERT(a_op_mod, out_valid_q && out_q.is_operational |-> out_q.module_life == LIFE_READY)
  `CMLA_ASSERT(a_dl_zero, out_valid_q && !out_q.deadline_valid |-> out_q.first_deadline == '0)
  `CMLA_ASSERT(a_up_alarm, out_valid_q |-> (out_q.port_up_mask & out_q.port_alarm_mask) == '0)
  `CMLA_ASSERT(a_out_src, $rose(out_valid_q) |-> $past(in_valid_q))
  `CMLA_ASSERT_RST(a_stall_empty, !in_valid_q |-> !in_stall_o)

endmodule
